@@ rtl/core/priority_queue_with_aging_unit_defines.svh @@
// Assertion macros shared by the priority queue checker
`ifndef PRIORITY_QUEUE_WITH_AGING_UNIT_DEFINES_SVH
`define PRIORITY_QUEUE_WITH_AGING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define PQA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PQA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pqa_pkg.sv @@
// Shared types, constants and helpers of the priority queue with aging
`default_nettype none

package pqa_pkg;

   localparam int ID_W   = 16;
   localparam int PRIO_W = 8;
   localparam int SLOT_W = 7;

   localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

   // Request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_TICK
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;   // capture the request fields
      logic insert;  // perform the insert (or reject) and load the response
      logic pop;     // dispatch the head entry and load the response
      logic age;     // age all remaining entries
   } pqa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic disp_zero;  // nothing left to dispatch on this tick
      logic disp_one;   // one entry left to dispatch on this tick
   } pqa_status_type;

   // Saturating priority increment
   function automatic logic [PRIO_W-1:0] prio_age(input logic [PRIO_W-1:0] p);
      prio_age = (p == PRIO_MAX) ? p : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/priority_queue_with_aging_unit.sv @@
// Top level of the priority queue with aging
//
//  Channel  Direction  Handshake              Payload
//  req_     in         req_valid/req_ready    op, entry_id, entry_priority, free_slots
//  rsp_     out        rsp_valid/rsp_ready    valid_res, out_id, out_priority, last,
//                                             rejected, queue_count
//
// A request is captured while idle and executed once the response register is free.
// A tick makes n = min(free_slots, entries) dispatches from the head of the shift store,
// one a cycle unless the response stalls; aging rides on the last, or alone if n is zero.
// Reset is synchronous; the store needs no clearing, only the entry and dispatch counts
// are zeroed. A stalled response holds execution; requests are captured only while idle.
`default_nettype none

module priority_queue_with_aging_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic [pqa_pkg::ID_W-1:0]      req_entry_id,
   input  wire logic [pqa_pkg::PRIO_W-1:0]    req_entry_priority,
   input  wire logic [pqa_pkg::SLOT_W-1:0]    req_free_slots,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid_res,
   output logic [pqa_pkg::ID_W-1:0]           rsp_out_id,
   output logic [pqa_pkg::PRIO_W-1:0]         rsp_out_priority,
   output logic                               rsp_last,
   output logic                               rsp_rejected,
   output logic [pqa_pkg::SLOT_W-1:0]         rsp_queue_count
);
   import pqa_pkg::*;

   pqa_cmd_type    cmd;
   pqa_status_type status;

   pqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pqa_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_entry_id       (req_entry_id),
      .req_entry_priority (req_entry_priority),
      .req_free_slots     (req_free_slots),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_last           (rsp_last),
      .rsp_rejected       (rsp_rejected),
      .rsp_queue_count    (rsp_queue_count)
   );

endmodule

`default_nettype wire

@@ rtl/core/pqa_ctrl.sv @@
// Controller state machine of the priority queue with aging
`default_nettype none

module pqa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire pqa_pkg::pqa_status_type status,
   output pqa_pkg::pqa_cmd_type       cmd
);
   import pqa_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           load;

   // State and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register may be loaded when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (req_op == OP_TICK) ? ST_TICK : ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (out_free) begin
               cmd.insert = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               if (status.disp_zero) begin
                  cmd.age  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop = 1'b1;
                  // last dispatch also ages the entries left behind
                  if (status.disp_one) begin
                     cmd.age  = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on load, cleared when taken
   assign load = cmd.insert || cmd.pop || cmd.age;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/core/pqa_datapath.sv @@
// Datapath of the priority queue with aging: sorted shift store and response register
`default_nettype none

module pqa_datapath #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pqa_pkg::ID_W-1:0]      req_entry_id,
   input  wire logic [pqa_pkg::PRIO_W-1:0]    req_entry_priority,
   input  wire logic [pqa_pkg::SLOT_W-1:0]    req_free_slots,
   input  wire pqa_pkg::pqa_cmd_type          cmd,
   output pqa_pkg::pqa_status_type            status,
   output logic                               rsp_valid_res,
   output logic [pqa_pkg::ID_W-1:0]           rsp_out_id,
   output logic [pqa_pkg::PRIO_W-1:0]         rsp_out_priority,
   output logic                               rsp_last,
   output logic                               rsp_rejected,
   output logic [pqa_pkg::SLOT_W-1:0]         rsp_queue_count
);
   import pqa_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   // Request capture
   logic [ID_W-1:0]   id_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [CNT_W-1:0]  disp_left_ff, disp_left_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Entry store, kept sorted with the head at index zero
   logic [ID_W-1:0]   ids_ff   [QUEUE_DEPTH];
   logic [ID_W-1:0]   ids_in   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] prios_ff [QUEUE_DEPTH];
   logic [PRIO_W-1:0] prios_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] ge;

   // Response payload
   logic              valid_res_ff;
   logic [ID_W-1:0]   out_id_ff;
   logic [PRIO_W-1:0] out_prio_ff;
   logic              last_ff;
   logic              rejected_ff;
   logic [CNT_W-1:0]  queue_count_ff;

   logic              full;
   logic [CNT_W-1:0]  slots_cnt;
   logic              slots_lt;

   assign full      = (count_ff == DEPTH_CNT);
   assign slots_lt  = (req_free_slots < SLOT_W'(count_ff));
   assign slots_cnt = CNT_W'(req_free_slots);

   // Dispatch bookkeeping on capture: n = min(free_slots, count)
   always_comb begin
      disp_left_in = disp_left_ff;
      remain_in    = remain_ff;
      if (cmd.latch) begin
         disp_left_in = slots_lt ? slots_cnt : count_ff;
         remain_in    = count_ff - (slots_lt ? slots_cnt : count_ff);
      end else if (cmd.pop) begin
         disp_left_in = disp_left_ff - 1'b1;
      end
   end

   assign status.disp_zero = (disp_left_ff == '0);
   assign status.disp_one  = (disp_left_ff == CNT_W'(1));

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.insert && !full) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Per-cell compare: new entry goes ahead of this cell (empty cells always qualify)
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ge[i] = (CNT_W'(i) >= count_ff) || (prio_ff >= prios_ff[i]);
      end
   end

   // Next store contents: insert shifts up, pop shifts down, aging increments
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ids_in[i]   = ids_ff[i];
         prios_in[i] = prios_ff[i];
      end
      if (cmd.insert && !full) begin
         if (ge[0]) begin
            ids_in[0]   = id_ff;
            prios_in[0] = prio_ff;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (ge[i-1]) begin
               ids_in[i]   = ids_ff[i-1];
               prios_in[i] = prios_ff[i-1];
            end else if (ge[i]) begin
               ids_in[i]   = id_ff;
               prios_in[i] = prio_ff;
            end
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            ids_in[i]   = ids_ff[i+1];
            prios_in[i] = cmd.age ? prio_age(prios_ff[i+1]) : prios_ff[i+1];
         end
      end else if (cmd.age) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            prios_in[i] = prio_age(prios_ff[i]);
         end
      end
   end

   // Control-state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         disp_left_ff <= '0;
      end else begin
         count_ff     <= count_in;
         disp_left_ff <= disp_left_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      if (cmd.latch) begin
         id_ff   <= req_entry_id;
         prio_ff <= req_entry_priority;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ids_ff[i]   <= ids_in[i];
         prios_ff[i] <= prios_in[i];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         valid_res_ff   <= 1'b1;
         out_id_ff      <= ids_ff[0];
         out_prio_ff    <= prios_ff[0];
         last_ff        <= status.disp_one;
         rejected_ff    <= 1'b0;
         queue_count_ff <= remain_ff;
      end else if (cmd.insert || cmd.age) begin
         valid_res_ff   <= 1'b0;
         out_id_ff      <= '0;
         out_prio_ff    <= '0;
         last_ff        <= 1'b1;
         rejected_ff    <= cmd.insert && full;
         queue_count_ff <= count_in;
      end
   end

   assign rsp_valid_res    = valid_res_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_last         = last_ff;
   assign rsp_rejected     = rejected_ff;
   assign rsp_queue_count  = SLOT_W'(queue_count_ff);

endmodule

`default_nettype wire

@@ rtl/core/pqa_checker.sv @@
// Port-level checker of the priority queue with aging, bound to the top level
`default_nettype none
`include "priority_queue_with_aging_unit_defines.svh"

module pqa_checker #(
   parameter int QUEUE_DEPTH = 64
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_valid_res,
   input wire logic [pqa_pkg::ID_W-1:0]   rsp_out_id,
   input wire logic                       rsp_last,
   input wire logic                       rsp_rejected,
   input wire logic [pqa_pkg::SLOT_W-1:0] rsp_queue_count
);
   import pqa_pkg::*;

   localparam logic [SLOT_W-1:0] DEPTH_CNT = SLOT_W'(QUEUE_DEPTH);

   // A stalled response keeps its payload
   `PQA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_id) && $stable(rsp_last), "response changed while stalled")

   // A refused insert is a single empty response
   `PQA_ASSERT_SAME(a_rej_shape, clock, reset, rsp_valid && rsp_rejected, rsp_last && !rsp_valid_res, "rejected response not a lone empty result")

   // Only a full queue refuses
   `PQA_ASSERT_SAME(a_rej_full, clock, reset, rsp_valid && rsp_rejected, rsp_queue_count == DEPTH_CNT, "insert refused below full")

   // The count never passes the depth
   `PQA_ASSERT_SAME(a_cnt_range, clock, reset, rsp_valid, rsp_queue_count <= DEPTH_CNT, "queue count above depth")

   // One request is in work at a time: no capture right after a capture
   `PQA_ASSERT_NEXT(a_one_req, clock, reset, req_valid && req_ready, !req_ready, "request taken on back-to-back cycles")

endmodule

bind priority_queue_with_aging_unit pqa_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pqa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_valid_res   (rsp_valid_res),
   .rsp_out_id      (rsp_out_id),
   .rsp_last        (rsp_last),
   .rsp_rejected    (rsp_rejected),
   .rsp_queue_count (rsp_queue_count)
);

`default_nettype wire
